### design/smx_pkg.sv
// Package: shared constants, types and the exp(-d) helper table for the softmax block.
`default_nettype none
package smx_pkg;
	localparam int unsigned MaxClassesDefault = 10;
	localparam logic [16:0] Log2eQ16 = 17'd94548;

	typedef struct packed {
		logic [6:0] count;
		logic       dropped;
		logic [15:0] max_val;
	} vec_desc_t;

	function automatic logic [16:0] pow2_frac(input logic [4:0] k);
		logic [16:0] t;
		case (k)
			5'd0: t = 17'd65536;
			5'd1: t = 17'd62757;
			5'd2: t = 17'd60097;
			5'd3: t = 17'd57549;
			5'd4: t = 17'd55109;
			5'd5: t = 17'd52773;
			5'd6: t = 17'd50535;
			5'd7: t = 17'd48392;
			5'd8: t = 17'd46341;
			5'd9: t = 17'd44376;
			5'd10: t = 17'd42495;
			5'd11: t = 17'd40693;
			5'd12: t = 17'd38968;
			5'd13: t = 17'd37316;
			5'd14: t = 17'd35734;
			5'd15: t = 17'd34219;
			5'd16: t = 17'd32768;
			default: t = 17'd0;
		endcase
		return t;
	endfunction
endpackage
`default_nettype wire

### design/smx_front.sv
// Front end: stores logits, tracks running max, hands a finished vector to the back end.
`default_nettype none
module smx_front import smx_pkg::*; #(
	parameter int unsigned MAX_CLASSES = MaxClassesDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        take,
	input  wire logic [15:0] logit,
	input  wire logic        last_logit,
	output logic             wr_en,
	output logic [5:0]       wr_addr,
	output logic [15:0]      wr_data,
	output logic             desc_valid,
	output vec_desc_t        desc
);
	logic [6:0]  count_q;
	logic [15:0] max_q;
	logic        drop_q;
	logic        room;
	logic [15:0] new_max;

	assign room    = count_q < 7'(MAX_CLASSES);
	assign wr_en   = take && room;
	assign wr_addr = count_q[5:0];
	assign wr_data = logit;
	assign new_max = (wr_en && $signed(logit) > $signed(max_q)) ? logit : max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			max_q      <= 16'h8000;
			drop_q     <= 1'b0;
			desc_valid <= 1'b0;
			desc       <= '0;
		end else begin
			desc_valid <= take && last_logit;
			if (take) begin
				if (last_logit) begin
					desc.count   <= wr_en ? count_q + 7'd1 : count_q;
					desc.dropped <= drop_q || !room;
					desc.max_val <= new_max;
					count_q      <= '0;
					max_q        <= 16'h8000;
					drop_q       <= 1'b0;
				end else begin
					if (room) count_q <= count_q + 7'd1;
					else drop_q <= 1'b1;
					max_q <= new_max;
				end
			end
		end
	end
endmodule
`default_nettype wire

### design/smx_ram.sv
// Generic single-write, single-read RAM with registered read.
`default_nettype none
module smx_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 10
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		rd_data <= mem_q[rd_addr];
	end
endmodule
`default_nettype wire

### design/smx_back.sv
// Back end: exp pass to form the sum, then a second exp pass with serial division per class.
`default_nettype none
module smx_back import smx_pkg::*; #(
	parameter int unsigned MAX_CLASSES = MaxClassesDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        desc_valid,
	input  vec_desc_t        desc,
	output logic             busy,
	output logic [5:0]       rd_addr,
	input  wire logic [15:0] rd_data,
	output logic             strobe,
	output logic [15:0]      probability,
	output logic [5:0]       class_index,
	output logic             last_probability,
	output logic             overflow
);
	typedef enum logic [2:0] {
		IDLE, RD, MUL, EXPV, ACC, DIV
	} state_t;
	state_t      state_q;
	logic        pass_q;
	logic [5:0]  idx_q;
	vec_desc_t   vec_q;
	logic [22:0] sum_q;
	logic [33:0] prod_q;
	logic [16:0] e_q;
	logic [40:0] rem_q;
	logic [15:0] quo_q;
	logic [4:0]  bit_q;
	logic        qfull_q;

	// desc queue, depth 1
	logic      qv_q;
	vec_desc_t qd_q;

	logic [16:0] d;
	logic [16:0] y;
	logic [6:0]  n;
	logic [3:0]  fi;
	logic [5:0]  fr;
	logic [16:0] hi, lo, v;
	logic [22:0] dlt;
	logic [16:0] e_n;
	logic [40:0] trial;
	logic        at_last;

	assign busy    = desc_valid || qv_q || (state_q != IDLE);
	assign rd_addr = idx_q;
	assign at_last = {1'b0, idx_q} == vec_q.count - 7'd1;
	assign d       = 17'($signed({vec_q.max_val[15], vec_q.max_val})
		- $signed({rd_data[15], rd_data}));
	assign y  = 17'((prod_q + 34'd32768) >> 16);
	assign n  = y[16:10];
	assign fi = y[9:6];
	assign fr = y[5:0];
	assign hi = pow2_frac({1'b0, fi});
	assign lo = pow2_frac(5'({1'b0, fi} + 5'd1));
	assign dlt = 23'((23'(hi - lo) * 23'(fr) + 23'd32) >> 6);
	assign v  = 17'(23'(hi) - dlt);
	always_comb begin
		if (n == 7'd0) e_n = v;
		else if (n > 7'd16) e_n = '0;
		else e_n = 17'((18'(v) + (18'd1 << (n - 7'd1))) >> n);
	end
	assign trial = rem_q - ({18'd0, sum_q} << bit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			qv_q <= 1'b0;
			qd_q <= '0;
			vec_q <= '0;
			strobe <= 1'b0;
			idx_q <= '0;
			pass_q <= 1'b0;
			sum_q <= '0;
			prod_q <= '0;
			e_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			bit_q <= '0;
			qfull_q <= 1'b0;
			probability <= '0;
			class_index <= '0;
			last_probability <= 1'b0;
			overflow <= 1'b0;
		end else begin
			strobe <= (state_q == DIV) && (bit_q == 5'd0);
			if (desc_valid) begin
				qv_q <= 1'b1;
				qd_q <= desc;
			end else if (state_q == IDLE) qv_q <= 1'b0;
			case (state_q)
				IDLE: if (qv_q) begin
					vec_q <= qd_q; idx_q <= '0;
					pass_q <= 1'b0; sum_q <= '0; state_q <= RD;
				end
				RD: state_q <= MUL;
				MUL: begin
					prod_q <= d * Log2eQ16;
					state_q <= EXPV;
				end
				EXPV: begin
					e_q <= e_n;
					state_q <= ACC;
				end
				ACC: begin
					if (!pass_q) begin
						sum_q <= sum_q + 23'(e_q);
						if (at_last) begin
							idx_q <= '0; pass_q <= 1'b1;
						end else idx_q <= idx_q + 6'd1;
						state_q <= RD;
					end else begin
						rem_q <= ({24'd0, e_q} << 16) + 41'(sum_q >> 1);
						quo_q <= '0; bit_q <= 5'd16; qfull_q <= 1'b0;
						state_q <= DIV;
					end
				end
				DIV: begin
					if (!trial[40]) begin
						rem_q <= trial;
						if (bit_q[4]) qfull_q <= 1'b1;
						else quo_q[bit_q[3:0]] <= 1'b1;
					end
					if (bit_q == 5'd0) begin
						probability <= qfull_q ? 16'hFFFF : (quo_q | {15'd0, !trial[40]});
						class_index <= idx_q;
						last_probability <= at_last;
						overflow <= vec_q.dropped;
						if (at_last) state_q <= IDLE;
						else begin
							idx_q <= idx_q + 6'd1; state_q <= RD;
						end
					end else bit_q <= bit_q - 5'd1;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != IDLE |-> {1'b0, idx_q} < 7'(MAX_CLASSES)) else $error("index out of range");
	a_strobe_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_probability |=> state_q == IDLE || state_q == RD)
		else $error("bad state after last");
	a_sum_min: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == DIV |-> sum_q >= 23'd65536) else $error("sum too small");
endmodule
`default_nettype wire

### design/softmax_normalizer.sv
// Top level: max-subtracted softmax over a stored vector of Q6.10 logits.
// A sum pass reads and exponentiates each of the N stored classes into the sum; then, per
// class, a second exp pass feeds a 17-step serial division. Logits load one per cycle while
// busy is low; busy is high from the cycle after the last logit until the last result is
// shown. The receiver cannot stall; each result is shown for one cycle with strobe.
// Reset clears counters, running max and flags; the score store is left as is.
`default_nettype none
module softmax_normalizer import smx_pkg::*; #(
	parameter int unsigned MAX_CLASSES = MaxClassesDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [15:0] logit,
	input  wire logic        last_logit,
	output logic             strobe,
	output logic [15:0]      probability,
	output logic [5:0]       class_index,
	output logic             last_probability,
	output logic             overflow
);
	localparam int unsigned AW = $clog2(MAX_CLASSES);
	logic        wr_en;
	logic [5:0]  wr_addr;
	logic [15:0] wr_data;
	logic        desc_valid;
	vec_desc_t   desc;
	logic [5:0]  rd_addr;
	logic [15:0] rd_data;

	smx_front #(.MAX_CLASSES(MAX_CLASSES)) u_front (
		.clk, .arst_n, .take(start && !busy), .logit, .last_logit,
		.wr_en, .wr_addr, .wr_data, .desc_valid, .desc
	);
	smx_ram #(.WIDTH(16), .DEPTH(MAX_CLASSES)) u_ram (
		.clk, .wr_en, .wr_addr(wr_addr[AW-1:0]), .wr_data,
		.rd_addr(rd_addr[AW-1:0]), .rd_data
	);
	smx_back #(.MAX_CLASSES(MAX_CLASSES)) u_back (
		.clk, .arst_n, .desc_valid, .desc, .busy, .rd_addr, .rd_data,
		.strobe, .probability, .class_index, .last_probability, .overflow
	);
endmodule
`default_nettype wire

### tb/tb.sv
// Testbench for softmax_normalizer: queued logit requests, predicted probabilities, strobe checks.
`default_nettype none
module tb;
	import smx_pkg::*;

	localparam int unsigned NCLS = MaxClassesDefault;

	typedef struct {
		logic [15:0] logit;
		logic        last;
	} req_t;

	typedef struct {
		logic [15:0] prob;
		logic [5:0]  idx;
		logic        last;
		logic        ovf;
	} prob_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [15:0] logit;
	logic last_logit;
	logic strobe;
	logic [15:0] probability;
	logic [5:0] class_index;
	logic last_probability;
	logic overflow;

	req_t  pending_q[$];
	prob_t expected_q[$];
	int    err_count;
	int    burst_left;
	int    gap_left;
	bit    hold_off;

	logic [15:0] scores[NCLS];
	logic signed [15:0] vec_max;
	int    vec_count;
	bit    vec_dropped;

	softmax_normalizer uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.logit(logit), .last_logit(last_logit), .strobe(strobe),
		.probability(probability), .class_index(class_index),
		.last_probability(last_probability), .overflow(overflow)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	task automatic report(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
		err_count++;
	endtask

	task automatic add_req(input req_t rq);
		pending_q.insert(pending_q.size(), rq);
	endtask

	task automatic add_expect(input prob_t res);
		expected_q.insert(expected_q.size(), res);
	endtask

	function automatic int unsigned exp_neg(input int unsigned d);
		longint unsigned y;
		int unsigned n, f, i, r, hi, lo, v;
		y = (longint'(d) * 94548 + 32768) >> 16;
		n = y >> 10;
		f = y & 1023;
		i = f >> 6;
		r = f & 63;
		hi = pow2_frac(i[4:0]);
		lo = pow2_frac(i[4:0] + 5'd1);
		v = hi - (((hi - lo) * r + 32) >> 6);
		if (n == 0)
			return v;
		if (n > 16)
			return 0;
		return (v + (1 << (n - 1))) >> n;
	endfunction

	task automatic predict_logit(input req_t rq);
		int unsigned total, e;
		longint unsigned p;
		prob_t res;
		if (vec_count < NCLS) begin
			scores[vec_count] = rq.logit;
			if ($signed(rq.logit) > vec_max)
				vec_max = rq.logit;
			vec_count++;
		end else begin
			vec_dropped = 1;
		end
		if (!rq.last)
			return;
		total = 0;
		for (int k = 0; k < vec_count; k++)
			total += exp_neg(int'(vec_max) - int'($signed(scores[k])));
		for (int k = 0; k < vec_count; k++) begin
			e = exp_neg(int'(vec_max) - int'($signed(scores[k])));
			p = (total == 0) ? 0 : ((longint'(e) << 16) + (total >> 1)) / total;
			res.prob = (p > 65535) ? 16'hFFFF : p[15:0];
			res.idx = k[5:0];
			res.last = (k + 1 == vec_count);
			res.ovf = vec_dropped;
			add_expect(res);
		end
		vec_max = 16'sh8000;
		vec_count = 0;
		vec_dropped = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 0;
			logit <= 0;
			last_logit <= 0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (start && !busy)
				predict_logit('{logit, last_logit});
			if (start && busy) begin
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 0;
			end else if (pending_q.size() > 0 && !(hold_off && expected_q.size() > 0)) begin
				req_t rq;
				rq = pending_q.pop_front();
				start <= 1;
				logit <= rq.logit;
				last_logit <= rq.last;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 12);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				start <= 0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (expected_q.size() == 0) begin
				report("unexpected result", class_index, -1);
			end else begin
				prob_t ex;
				ex = expected_q.pop_front();
				if (probability !== ex.prob)
					report("probability", probability, ex.prob);
				if (class_index !== ex.idx)
					report("class_index", class_index, ex.idx);
				if (last_probability !== ex.last)
					report("last_probability", last_probability, ex.last);
				if (overflow !== ex.ovf)
					report("overflow", overflow, ex.ovf);
			end
		end
	end

	task automatic add_vector(input int len, input int mode);
		req_t rq;
		logic [15:0] base;
		base = 16'($urandom);
		for (int k = 0; k < len; k++) begin
			case (mode)
				0: rq.logit = 16'($urandom);
				1: rq.logit = 16'(base + $urandom_range(0, 4096) - 2048);
				default: rq.logit = ($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000;
			endcase
			rq.last = (k == len - 1);
			add_req(rq);
		end
	endtask

	initial begin
		int total;
		err_count = 0;
		hold_off = 0;
		vec_max = 16'sh8000;
		vec_count = 0;
		vec_dropped = 0;
		arst_n = 0;
		start = 0;
		logit = 0;
		last_logit = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		// directed: sole class, extremes, ties, overflow with dropped last
		add_req('{16'h7FFF, 1'b1});
		add_req('{16'h8000, 1'b1});
		add_req('{16'h7FFF, 1'b0});
		add_req('{16'h8000, 1'b1});
		add_req('{16'h0000, 1'b0});
		add_req('{16'h0000, 1'b0});
		add_req('{16'h0400, 1'b1});
		for (int k = 0; k < 12; k++)
			add_req('{16'(k * 300 - 1500), 1'(k == 11)});
		wait (pending_q.size() == 0 && !start);
		hold_off = 1;
		wait (expected_q.size() == 0);
		repeat (30) @(posedge clk);
		hold_off = 0;
		total = 0;
		while (total < 80) begin
			int len;
			len = ($urandom_range(0, 5) == 0) ? $urandom_range(11, 14) : $urandom_range(1, 10);
			add_vector(len, $urandom_range(0, 4) == 0 ? 2 : $urandom_range(0, 1));
			total += len;
		end
		wait (pending_q.size() == 0 && !start);
		wait (expected_q.size() == 0);
		repeat (300) @(posedge clk);
		if (err_count == 0 && expected_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#3000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire
